@@ hw/rtl/ucdp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the USB configuration descriptor parser.
// No dependencies.
package ucdp_pkg;

	// Record kinds on the result channel
	typedef enum logic [1:0] {
		KIND_IFACE = 2'd0,
		KIND_EP    = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Descriptor type codes of interest
	localparam logic [7:0] DT_INTERFACE = 8'h04;
	localparam logic [7:0] DT_ENDPOINT  = 8'h05;

	// Minimum lengths for a usable descriptor
	localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
	localparam logic [7:0] EP_MIN_LEN    = 8'd7;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot;
		logic [7:0]  cls;
		logic [7:0]  subcls;
		logic [7:0]  proto;
		logic [7:0]  addr;
		logic [1:0]  ep_type;
		logic        dir;
		logic [10:0] mps;
		logic [7:0]  ival;
		logic [3:0]  total;
		logic        last;
	} rec_t;

endpackage

@@ hw/rtl/usb_config_descriptor_parser.sv @@
`timescale 1ns / 1ps
// USB configuration descriptor parser, top level.
// Depends on ucdp_pkg; checked by ucdp_checker (bound in its own file).
//
// Takes a configuration descriptor stream one byte per item (data_byte, with
// final_byte on the last byte) and walks the descriptor chain by each length
// byte. Interface descriptors (length >= 9) yield an interface record while
// fewer than MAX_IFACES have been recorded; endpoint descriptors (length >= 7)
// yield an endpoint record in slot (address & 0xF) * 2 + direction when that
// slot is below 2 * MAX_EP_NUMBERS. A zero length byte halts parsing until the
// final byte. The final byte always yields a done record (after any record
// completed on the same byte) and returns the parser to its reset state.
// Throughput: one byte per cycle while in_stall is low. The parse logic runs in the
// accepting cycle and pushes zero, one or two records into a 4-entry result
// queue; the queue drains one record per cycle while out_stall is low, and
// in_stall rises while more than two entries are held. When the queue is empty,
// the first record of an accepted byte is presented in the next cycle.
module usb_config_descriptor_parser #(
	parameter int MAX_IFACES     = 8,
	parameter int MAX_EP_NUMBERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	// record channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [4:0]  slot_index,
	output logic [7:0]  iface_class,
	output logic [7:0]  iface_subclass,
	output logic [7:0]  iface_protocol,
	output logic [7:0]  ep_address,
	output logic [1:0]  ep_type,
	output logic        ep_direction,
	output logic [10:0] max_packet,
	output logic [7:0]  poll_interval,
	output logic [3:0]  interface_total,
	output logic        last_record
);
	import ucdp_pkg::*;

	// parser state
	logic [7:0]  pos_q, len_q, type_q;
	logic [39:0] cap_q;
	logic [3:0]  ifc_q;
	logic        stop_q;

	logic [7:0]  n_pos, n_len, n_type;
	logic [39:0] n_cap;
	logic [3:0]  n_ifc;
	logic        n_stop;

	rec_t        rec, done_rec;
	logic        rec_fire;
	logic [4:0]  ep_slot;

	// result queue
	rec_t        q_mem [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  cnt_q;
	logic        push, pop;
	rec_t        head;

	assign push      = in_valid && !in_stall;
	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	// room for two records, whatever leaves this cycle
	assign in_stall  = (cnt_q > 3'd2);

	always_comb begin
		n_pos    = pos_q;
		n_len    = len_q;
		n_type   = type_q;
		n_cap    = cap_q;
		n_ifc    = ifc_q;
		n_stop   = stop_q;
		rec_fire = 1'b0;
		rec      = '0;
		ep_slot  = '0;

		if (!stop_q) begin
			if (pos_q == 8'd0) begin
				// length byte of a new descriptor
				if (data_byte == 8'd0) begin
					n_stop = 1'b1;
				end else begin
					n_len  = data_byte;
					n_type = 8'd0;
					n_cap  = '0;
					if (data_byte >= 8'd2) begin
						n_pos = 8'd1;
					end
				end
			end else begin
				if (pos_q == 8'd1) begin
					n_type = data_byte;
				end else if (type_q == DT_INTERFACE) begin
					case (pos_q)
						8'd5:    n_cap[7:0]   = data_byte;
						8'd6:    n_cap[15:8]  = data_byte;
						8'd7:    n_cap[23:16] = data_byte;
						default: ;
					endcase
				end else if (type_q == DT_ENDPOINT) begin
					case (pos_q)
						8'd2:    n_cap[7:0]   = data_byte;
						8'd3:    n_cap[15:8]  = data_byte;
						8'd4:    n_cap[23:16] = data_byte;
						8'd5:    n_cap[31:24] = data_byte;
						8'd6:    n_cap[39:32] = data_byte;
						default: ;
					endcase
				end

				if (({1'b0, pos_q} + 9'd1) == {1'b0, len_q}) begin
					// last byte of this descriptor: decide on a record
					n_pos   = 8'd0;
					ep_slot = {n_cap[3:0], n_cap[7]};
					if (n_type == DT_INTERFACE && len_q >= IFACE_MIN_LEN) begin
						if (ifc_q < 4'(MAX_IFACES)) begin
							rec_fire   = 1'b1;
							n_ifc      = ifc_q + 4'd1;
							rec.kind   = KIND_IFACE;
							rec.slot   = {1'b0, ifc_q};
							rec.cls    = n_cap[7:0];
							rec.subcls = n_cap[15:8];
							rec.proto  = n_cap[23:16];
							rec.total  = ifc_q + 4'd1;
						end
					end else if (n_type == DT_ENDPOINT && len_q >= EP_MIN_LEN) begin
						if ({1'b0, ep_slot} < 6'(2 * MAX_EP_NUMBERS)) begin
							rec_fire    = 1'b1;
							rec.kind    = KIND_EP;
							rec.slot    = ep_slot;
							rec.addr    = n_cap[7:0];
							rec.ep_type = n_cap[9:8];
							rec.dir     = n_cap[7];
							rec.mps     = {n_cap[26:24], n_cap[23:16]};
							rec.ival    = n_cap[39:32];
							rec.total   = ifc_q;
						end
					end
				end else begin
					n_pos = pos_q + 8'd1;
				end
			end
		end

		done_rec       = '0;
		done_rec.kind  = KIND_DONE;
		done_rec.total = n_ifc;
		done_rec.last  = 1'b1;

		// end of stream: back to reset state
		if (final_byte) begin
			n_pos  = 8'd0;
			n_len  = 8'd0;
			n_type = 8'd0;
			n_cap  = '0;
			n_ifc  = 4'd0;
			n_stop = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			type_q <= '0;
			cap_q  <= '0;
			ifc_q  <= '0;
			stop_q <= 1'b0;
		end else if (push) begin
			pos_q  <= n_pos;
			len_q  <= n_len;
			type_q <= n_type;
			cap_q  <= n_cap;
			ifc_q  <= n_ifc;
			stop_q <= n_stop;
		end
	end

	// queue storage: record first, done record after it
	always_ff @(posedge clk) begin
		if (push) begin
			if (rec_fire) begin
				q_mem[wr_ptr_q] <= rec;
			end
			if (final_byte) begin
				q_mem[wr_ptr_q + 2'(rec_fire)] <= done_rec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'(rec_fire) + 2'(final_byte);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q
				+ (push ? (3'(rec_fire) + 3'(final_byte)) : 3'd0)
				- 3'(pop);
		end
	end

	assign head            = q_mem[rd_ptr_q];
	assign record_kind     = head.kind;
	assign slot_index      = head.slot;
	assign iface_class     = head.cls;
	assign iface_subclass  = head.subcls;
	assign iface_protocol  = head.proto;
	assign ep_address      = head.addr;
	assign ep_type         = head.ep_type;
	assign ep_direction    = head.dir;
	assign max_packet      = head.mps;
	assign poll_interval   = head.ival;
	assign interface_total = head.total;
	assign last_record     = head.last;

endmodule

@@ hw/rtl/ucdp_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for usb_config_descriptor_parser, plus the bind.
// Depends on ucdp_pkg.
module ucdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        final_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  record_kind,
	input logic [4:0]  slot_index,
	input logic [7:0]  ep_address,
	input logic        ep_direction,
	input logic [3:0]  interface_total,
	input logic        last_record
);
	import ucdp_pkg::*;

	// a held record does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(record_kind)
			&& $stable(slot_index) && $stable(last_record))
		else $error("stalled record changed");

	// only done records end a run
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_record == (record_kind == KIND_DONE)))
		else $error("last_record does not match done kind");

	// interface numbering counts itself
	a_iface: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_IFACE
			|-> ({1'b0, interface_total} == slot_index + 5'd1))
		else $error("interface slot and total disagree");

	// endpoint slot from address and direction
	a_ep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_EP
			|-> (slot_index == {ep_address[3:0], ep_address[7]})
			&& (ep_direction == ep_address[7]))
		else $error("endpoint slot mismatch");

	// a final byte always leaves at least a done record queued
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_byte |=> out_valid)
		else $error("no record after final byte");

endmodule

bind usb_config_descriptor_parser ucdp_checker u_ucdp_checker (.*);
